FILE: rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion macros shared by the RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/piq_pkg.sv
// piq_pkg: types, codes and constants of the priority inbox queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package piq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int PRIO_W     = 3;
  localparam int TSTAMP_W   = 32;
  localparam int MSG_TYPE_W = 3;
  localparam int HANDLE_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int OUT_CNT_W  = 5;
  localparam int FILTER_W   = 4;
  localparam int NUM_TYPES  = 2 ** MSG_TYPE_W;

  // Operation codes
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                  kind;
    logic [PRIO_W-1:0]     in_priority;
    logic [TSTAMP_W-1:0]   in_timestamp;
    logic [MSG_TYPE_W-1:0] in_msg_type;
    logic [HANDLE_W-1:0]   in_handle;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PRIO_W-1:0]     out_priority;
    logic [TSTAMP_W-1:0]   out_timestamp;
    logic [MSG_TYPE_W-1:0] out_msg_type;
    logic [HANDLE_W-1:0]   out_handle;
    logic [OUT_CNT_W-1:0]  total_count;
    logic [OUT_CNT_W-1:0]  filtered_count;
  } out_item_t;

  // One stored entry
  typedef struct packed {
    logic [PRIO_W-1:0]     prio;
    logic [TSTAMP_W-1:0]   tstamp;
    logic [MSG_TYPE_W-1:0] msg_type;
    logic [HANDLE_W-1:0]   handle;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic shift;
    logic load_out;
  } piq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic scan_last;
    logic shift_done;
    logic out_free;
  } piq_stat_t;

endpackage

FILE: rtl/piq_ram.sv
// piq_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module piq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/piq_ctrl.sv
// piq_ctrl: controller state machine of the priority inbox queue.
// Depends on piq_pkg for the command and status structs and operation codes.
module piq_ctrl
  import piq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_kind,
  output logic      in_stall,
  input  piq_stat_t stat,
  output piq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd.accept   = accept;
    cmd.scan     = (state_r == S_SCAN);
    cmd.shift    = (state_r == S_SHIFT);
    cmd.load_out = (state_r == S_DONE) && stat.out_free;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if ((in_kind == KIND_POP) && !stat.empty) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/piq_dp.sv
// piq_dp: datapath of the priority inbox queue: entry RAM, scan and shift
// pointers, counters, type filter and result register. Uses piq_pkg, piq_ram.
`include "assert_macros.svh"

module piq_dp
  import piq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  piq_cmd_t                   cmd,
  output piq_stat_t                  stat,
  input  in_item_t                   in_data,
  input  logic                       cfg_wr_en,
  input  logic signed [FILTER_W-1:0] cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_item_t                  out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = $bits(entry_t);

  // Control state
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [CW-1:0]              type_cnt_r [NUM_TYPES];
  logic [CW-1:0]              type_cnt_nxt [NUM_TYPES];
  logic signed [FILTER_W-1:0] filt_r;
  logic                       out_valid_r;

  // Working registers
  logic [AW-1:0]       vidx_r;
  logic [AW-1:0]       best_idx_r;
  logic [AW-1:0]       wr_idx_r;
  entry_t              best_r;
  logic [STATUS_W-1:0] status_r;
  out_item_t           out_data_r;

  logic          full, push_ok, pop_commit, take;
  logic [AW-1:0] last_idx, best_idx_fin;
  logic [CW-1:0] filt_cnt;
  entry_t        rd_entry, wr_entry;
  logic [EW-1:0] ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;

  piq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // Status toward the controller
  assign last_idx   = AW'(cnt_r - CW'(1));
  assign full       = (cnt_r == CW'(DEPTH));
  assign stat.empty      = (cnt_r == '0);
  assign stat.scan_last  = (vidx_r == last_idx);
  assign stat.shift_done = (wr_idx_r == last_idx);
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign push_ok    = cmd.accept && (in_data.kind == KIND_PUSH) && !full;
  assign pop_commit = cmd.shift && stat.shift_done;

  // Scan compare: higher priority wins, then smaller timestamp, first seen on a full tie
  assign take = (vidx_r == '0) ||
                (rd_entry.prio > best_r.prio) ||
                ((rd_entry.prio == best_r.prio) && (rd_entry.tstamp < best_r.tstamp));
  assign best_idx_fin = take ? vidx_r : best_idx_r;

  // RAM read address: start of scan, next scan slot, or the entry above the hole
  always_comb begin
    priority if (cmd.accept) begin
      ram_raddr = '0;
    end else if (cmd.scan) begin
      ram_raddr = stat.scan_last ? (best_idx_fin + AW'(1)) : (vidx_r + AW'(1));
    end else begin
      ram_raddr = wr_idx_r + AW'(2);
    end
  end

  // RAM write: push appends at the end, shift moves an entry down one place
  always_comb begin
    if (cmd.shift) begin
      ram_we    = !stat.shift_done;
      ram_waddr = wr_idx_r;
      wr_entry  = rd_entry;
    end else begin
      ram_we          = push_ok;
      ram_waddr       = AW'(cnt_r);
      wr_entry.prio     = in_data.in_priority;
      wr_entry.tstamp   = in_data.in_timestamp;
      wr_entry.msg_type = in_data.in_msg_type;
      wr_entry.handle   = in_data.in_handle;
    end
  end

  // Total and per-type counters
  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop_commit) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    for (int t = 0; t < NUM_TYPES; t++) begin
      type_cnt_nxt[t] = type_cnt_r[t];
      if (push_ok && (in_data.in_msg_type == MSG_TYPE_W'(t))) begin
        type_cnt_nxt[t] = type_cnt_r[t] + CW'(1);
      end else if (pop_commit && (best_r.msg_type == MSG_TYPE_W'(t))) begin
        type_cnt_nxt[t] = type_cnt_r[t] - CW'(1);
      end
    end
  end

  // Negative filter counts everything
  assign filt_cnt = filt_r[FILTER_W-1] ? cnt_r : type_cnt_r[filt_r[MSG_TYPE_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      filt_r      <= '1;
      out_valid_r <= 1'b0;
      for (int t = 0; t < NUM_TYPES; t++) begin
        type_cnt_r[t] <= '0;
      end
    end else begin
      cnt_r <= cnt_nxt;
      for (int t = 0; t < NUM_TYPES; t++) begin
        type_cnt_r[t] <= type_cnt_nxt[t];
      end
      if (cfg_wr_en) begin
        filt_r <= cfg_wr_data;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan, shift and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      best_r <= '0;
      vidx_r <= '0;
      if (in_data.kind == KIND_PUSH) begin
        status_r <= full ? ST_FULL : ST_OK;
      end else begin
        status_r <= stat.empty ? ST_EMPTY : ST_OK;
      end
    end
    if (cmd.scan) begin
      vidx_r <= vidx_r + AW'(1);
      if (take) begin
        best_r     <= rd_entry;
        best_idx_r <= vidx_r;
      end
      if (stat.scan_last) begin
        wr_idx_r <= best_idx_fin;
      end
    end
    if (cmd.shift && !stat.shift_done) begin
      wr_idx_r <= wr_idx_r + AW'(1);
    end
    if (cmd.load_out) begin
      out_data_r.status         <= status_r;
      out_data_r.out_priority   <= best_r.prio;
      out_data_r.out_timestamp  <= best_r.tstamp;
      out_data_r.out_msg_type   <= best_r.msg_type;
      out_data_r.out_handle     <= best_r.handle;
      out_data_r.total_count    <= OUT_CNT_W'(cnt_r);
      out_data_r.filtered_count <= OUT_CNT_W'(filt_cnt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_cnt_in_range, cnt_r <= CW'(DEPTH), "entry count above capacity")
  `ASSERT_ALWAYS(a_filt_le_total, filt_cnt <= cnt_r, "filtered count above total count")
  `ASSERT_NEXT(a_pop_dec, pop_commit, cnt_r == $past(cnt_r) - CW'(1), "pop did not drop count")
  `ASSERT_IMPL(a_no_push_full, ram_we && !cmd.shift, !full, "write into a full store")

endmodule

FILE: rtl/priority_inbox_queue.sv
// priority_inbox_queue: fixed-capacity inbox that serves entries by priority.
// Push: from acceptance the controller goes to DONE and loads the result. Pop of n
// stored entries with the winner at place b: the RAM scan reads all n entries, the
// entries above b shift down one place, and the result is loaded.
// One item at a time; the next is taken the cycle after the result is loaded.
// Synchronous active-low reset empties the store and sets the type filter to -1.
module priority_inbox_queue
  import piq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output out_item_t                  out_data,
  input  logic                       cfg_wr_en,
  input  logic signed [FILTER_W-1:0] cfg_wr_data
);

  piq_cmd_t  cmd;
  piq_stat_t stat;

  // Sequencer
  piq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, counters and result register
  piq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
